@@ rtl/ycc_pkg.sv @@
// Package with the types, fixed-point coefficients and lane tables of the color converter.
`default_nettype none

package ycc_pkg;

	// Fraction bits of the fixed-point coefficients.
	localparam int COEFF_FRAC_BITS = 16;

	// Coefficient width: magnitudes stay below 2^(F+2), plus a sign bit.
	localparam int COEF_W = COEFF_FRAC_BITS + 3;
	// Operand width: an 8-bit component or its signed offset form.
	localparam int OPND_W = 9;
	// Accumulator width: one product, with room for the three-term sum.
	localparam int ACC_W  = COEF_W + OPND_W;

	// Pipeline depth from input beat to output register.
	localparam int NUM_STAGES = 4;

	// Scaling of coefficients given in millionths.
	localparam longint Q_MILLION = 1000000;
	localparam longint Q_ROUND   = 500000;

	// Coefficients, round(c * 2^F).
	localparam longint K_Y_GAIN = ((64'sd1164383 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_R_CR   = ((64'sd1596027 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_G_CB   = ((64'sd391762 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_G_CR   = ((64'sd812968 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_B_CB   = ((64'sd2017232 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_Y_R    = ((64'sd256788 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_Y_G    = ((64'sd504129 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_Y_B    = ((64'sd97906 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_CB_R   = ((64'sd148223 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_CB_G   = ((64'sd290993 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_C_HALF = ((64'sd439216 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_CR_G   = ((64'sd367788 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;
	localparam longint K_CR_B   = ((64'sd71427 << COEFF_FRAC_BITS) + Q_ROUND) / Q_MILLION;

	// Rounding constant and the luma and chroma offsets with rounding folded in.
	localparam longint Q_HALF    = 64'sd1 << (COEFF_FRAC_BITS - 1);
	localparam longint Q_OFF_16  = (64'sd16 << COEFF_FRAC_BITS) + Q_HALF;
	localparam longint Q_OFF_128 = (64'sd128 << COEFF_FRAC_BITS) + Q_HALF;

	// Direction register codes.
	localparam logic DIR_YCC_TO_RGB = 1'b0;
	localparam logic DIR_RGB_TO_YCC = 1'b1;

	// Lane codes: one lane for each output component.
	localparam logic [1:0] LANE_FIRST  = 2'd0;
	localparam logic [1:0] LANE_SECOND = 2'd1;
	localparam logic [1:0] LANE_THIRD  = 2'd2;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// Input and output pixel beats.
	typedef struct packed {
		logic [7:0] in_first;
		logic [7:0] in_second;
		logic [7:0] in_third;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [7:0] out_third;
	} pix_out_t;

	// Coefficients and offset applied by one lane.
	typedef struct packed {
		coef_t c0;
		coef_t c1;
		coef_t c2;
		acc_t  offset;
	} coef_set_t;

	// Per-stage load enables from the pipeline control.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Coefficient set of one lane for the given direction.
	function automatic coef_set_t lane_coefs(input logic [1:0] lane, input logic dir);
		coef_set_t cs;
		cs = '{c0: '0, c1: '0, c2: '0, offset: '0};
		if (dir == DIR_YCC_TO_RGB) begin
			unique case (lane)
				LANE_FIRST: begin
					cs = '{c0: coef_t'(K_Y_GAIN), c1: '0, c2: coef_t'(K_R_CR), offset: '0};
				end
				LANE_SECOND: begin
					cs = '{c0: coef_t'(K_Y_GAIN), c1: coef_t'(-K_G_CB), c2: coef_t'(-K_G_CR),
						offset: '0};
				end
				LANE_THIRD: begin
					cs = '{c0: coef_t'(K_Y_GAIN), c1: coef_t'(K_B_CB), c2: '0, offset: '0};
				end
				default: begin
					cs = '{c0: '0, c1: '0, c2: '0, offset: '0};
				end
			endcase
		end else begin
			unique case (lane)
				LANE_FIRST: begin
					cs = '{c0: coef_t'(K_Y_R), c1: coef_t'(K_Y_G), c2: coef_t'(K_Y_B),
						offset: acc_t'(Q_OFF_16)};
				end
				LANE_SECOND: begin
					cs = '{c0: coef_t'(-K_CB_R), c1: coef_t'(-K_CB_G), c2: coef_t'(K_C_HALF),
						offset: acc_t'(Q_OFF_128)};
				end
				LANE_THIRD: begin
					cs = '{c0: coef_t'(K_C_HALF), c1: coef_t'(-K_CR_G), c2: coef_t'(-K_CR_B),
						offset: acc_t'(Q_OFF_128)};
				end
				default: begin
					cs = '{c0: '0, c1: '0, c2: '0, offset: '0};
				end
			endcase
		end
		return cs;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ycbcr_rgb_color_convert_top.sv @@
// An accepted beat passes the operand, product, sum and output registers before it shows on out_valid.
// Throughput: one pixel per clock; each stage holds when the next one is full and stalled.
// The multiply stage (about 9 x 19 bits per product) and the four-term add set the depth.
// Reset clears all stage valid bits and sets the direction to YCbCr to RGB.
// Stage 1 forms operands, stage 2 multiplies, stage 3 sums, stage 4 saturates.
`default_nettype none

module ycbcr_rgb_color_convert_top import ycc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire pix_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output pix_out_t     out_data
);

	logic      dir_q;
	logic      dir_s1;
	opnd_t     op0_s1;
	opnd_t     op1_s1;
	opnd_t     op2_s1;
	stage_en_t en;
	coef_set_t cs_first;
	coef_set_t cs_second;
	coef_set_t cs_third;
	logic [7:0] pix_first;
	logic [7:0] pix_second;
	logic [7:0] pix_third;

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_YCC_TO_RGB;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	ycc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.en        (en)
	);

	// Operands: offset luma and chroma for YCbCr input, plain components for RGB.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			dir_s1 <= dir_q;
			if (dir_q == DIR_YCC_TO_RGB) begin
				op0_s1 <= opnd_t'({1'b0, in_data.in_first}) - opnd_t'(16);
				op1_s1 <= opnd_t'({1'b0, in_data.in_second}) - opnd_t'(128);
				op2_s1 <= opnd_t'({1'b0, in_data.in_third}) - opnd_t'(128);
			end else begin
				op0_s1 <= opnd_t'({1'b0, in_data.in_first});
				op1_s1 <= opnd_t'({1'b0, in_data.in_second});
				op2_s1 <= opnd_t'({1'b0, in_data.in_third});
			end
		end
	end

	// Coefficient sets follow the direction carried with the beat.
	assign cs_first  = lane_coefs(LANE_FIRST, dir_s1);
	assign cs_second = lane_coefs(LANE_SECOND, dir_s1);
	assign cs_third  = lane_coefs(LANE_THIRD, dir_s1);

	ycc_lane u_lane_first (
		.clk    (clk),
		.en     (en),
		.op0_s1 (op0_s1),
		.op1_s1 (op1_s1),
		.op2_s1 (op2_s1),
		.cs     (cs_first),
		.pix_s4 (pix_first)
	);

	ycc_lane u_lane_second (
		.clk    (clk),
		.en     (en),
		.op0_s1 (op0_s1),
		.op1_s1 (op1_s1),
		.op2_s1 (op2_s1),
		.cs     (cs_second),
		.pix_s4 (pix_second)
	);

	ycc_lane u_lane_third (
		.clk    (clk),
		.en     (en),
		.op0_s1 (op0_s1),
		.op1_s1 (op1_s1),
		.op2_s1 (op2_s1),
		.cs     (cs_third),
		.pix_s4 (pix_third)
	);

	assign out_data = '{out_first: pix_first, out_second: pix_second, out_third: pix_third};

endmodule

`default_nettype wire

@@ rtl/ycc_ctrl.sv @@
// Valid tracking and stall control of the four-stage conversion pipeline.
`default_nettype none

module ycc_ctrl import ycc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      out_ready,
	output logic           in_ready,
	output logic           out_valid,
	output stage_en_t      en
);

	logic [NUM_STAGES-1:0] stage_valid_q;
	logic [NUM_STAGES-1:0] load;
	logic [NUM_STAGES-1:0] upstream_valid;

	// A stage loads when it is empty or its contents move on this cycle.
	always_comb begin
		load[NUM_STAGES-1] = !stage_valid_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			load[i] = !stage_valid_q[i] || load[i+1];
		end
	end

	// Valid bit feeding each stage.
	always_comb begin
		upstream_valid[0] = in_valid;
		for (int i = 1; i < NUM_STAGES; i++) begin
			upstream_valid[i] = stage_valid_q[i-1];
		end
	end

	// Valid bits advance with their beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (load[i]) begin
					stage_valid_q[i] <= upstream_valid[i];
				end
			end
		end
	end

	assign en        = '{s1: load[0], s2: load[1], s3: load[2], s4: load[3]};
	assign in_ready  = load[0];
	assign out_valid = stage_valid_q[NUM_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/ycc_lane.sv @@
// One output component: three products, their sum with offset, then saturation.
`default_nettype none

module ycc_lane import ycc_pkg::*; (
	input  wire logic      clk,
	input  wire stage_en_t en,
	input  wire opnd_t     op0_s1,
	input  wire opnd_t     op1_s1,
	input  wire opnd_t     op2_s1,
	input  wire coef_set_t cs,
	output logic [7:0]     pix_s4
);

	acc_t prod0_s2;
	acc_t prod1_s2;
	acc_t prod2_s2;
	acc_t offset_s2;
	acc_t sum_s3;
	logic [7:0] sat_byte;

	// Products of the operands with the lane coefficients.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod0_s2  <= op0_s1 * cs.c0;
			prod1_s2  <= op1_s1 * cs.c1;
			prod2_s2  <= op2_s1 * cs.c2;
			offset_s2 <= cs.offset;
		end
	end

	// Sum of the three products and the offset; the offset carries the rounding only for RGB to YCbCr.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= prod0_s2 + prod1_s2 + prod2_s2 + offset_s2;
		end
	end

	// Drop the fraction and saturate to 0..255.
	always_comb begin
		if (sum_s3[ACC_W-1]) begin
			sat_byte = 8'd0;
		end else if (|sum_s3[ACC_W-2:COEFF_FRAC_BITS+8]) begin
			sat_byte = 8'd255;
		end else begin
			sat_byte = sum_s3[COEFF_FRAC_BITS+7:COEFF_FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pix_s4 <= sat_byte;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ycc_checker.sv @@
// Port-level checks of the color converter, bound to the top level.
`default_nettype none

module ycc_checker import ycc_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire pix_out_t out_data
);

	// A stalled output beat stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// An empty output stage means the pipeline can take a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// A draining output never back-pressures the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// With the output draining, an accepted beat reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted beat did not reach the output");

endmodule

bind ycbcr_rgb_color_convert_top ycc_checker u_ycc_checker (.*);

`default_nettype wire
